// ===== hdl/gbq_pkg.sv =====
// Shared types, codes and arithmetic helpers for the 5x5 blur / quantize block.
// No dependencies.
package gbq_pkg;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel;
  } gbq_in_t;

  typedef struct packed {
    logic [7:0] blurred_level;
    logic       last_in_frame;
  } gbq_out_t;

  typedef logic [2:0] tap_sel_t;

  // Per-beat control that travels down the pipe with the data.
  typedef struct packed {
    logic            valid;
    logic            push;
    logic            emit;
    logic            last;
    logic [7:0]      pixel;
    tap_sel_t [4:0]  vsel;
    tap_sel_t [4:0]  hsel;
  } gbq_item_t;

  // Mirror without repeating the edge sample.
  function automatic logic signed [18:0] mirror(input logic signed [18:0] v,
                                                input logic signed [18:0] n);
    logic signed [18:0] m;
    m = (v < 0) ? -v : v;
    if (m >= n) m = 19'sd2 * n - m - 19'sd2;
    return m;
  endfunction

  // 1,4,6,4,1 taps.
  function automatic logic [15:0] binom5(input logic [11:0] a, input logic [11:0] b,
                                         input logic [11:0] c, input logic [11:0] d,
                                         input logic [11:0] e);
    logic [15:0] a16, b16, c16, d16, e16;
    a16 = {4'b0, a};
    b16 = {4'b0, b};
    c16 = {4'b0, c};
    d16 = {4'b0, d};
    e16 = {4'b0, e};
    return a16 + (b16 << 2) + (c16 << 2) + (c16 << 1) + (d16 << 2) + e16;
  endfunction

endpackage

// ===== hdl/gbq_ctrl.sv =====
// Frame position counters, config registers and tap selection (stage 0).
// Depends on gbq_pkg.
module gbq_ctrl import gbq_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  adv_i,
  input  gbq_in_t               in_beat_i,
  output logic [CW-1:0]         rd_col_o,
  output gbq_item_t             item_o,
  output logic [CW-1:0]         col_o
);

  logic [11:0] fwidth_q, fwidth_d;
  logic [15:0] fheight_q, fheight_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d, col_q, col_d;
  logic [16:0]   in_row_q, in_row_d;
  logic [15:0]   out_row_q, out_row_d;
  gbq_item_t     item_q, item_d;

  logic [CW:0]  w_eff;
  logic [15:0]  h_eff;
  logic         drain, done, act_push, act_drain, act, emit, last;
  tap_sel_t [4:0] vsel, hsel;

  always_comb begin
    if (fwidth_q < 12'd3) w_eff = (CW+1)'(3);
    else if (int'(fwidth_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(fwidth_q);
    h_eff = (fheight_q < 16'd3) ? 16'd3 : fheight_q;
  end

  assign drain     = (in_beat_i.operation == OP_DRAIN);
  assign done      = (in_row_q >= {1'b0, h_eff});
  assign act_push  = !drain && !done;
  assign act_drain = drain && done;
  assign act       = act_push || act_drain;
  assign emit      = act_drain ||
                     (act_push && ((in_row_q > 17'd2) ||
                                   ((in_row_q == 17'd2) && (in_col_q >= CW'(2)))));
  assign last      = (out_row_q == h_eff - 16'd1) &&
                     ({1'b0, out_col_q} == w_eff - (CW+1)'(1));

  // Vertical taps index the column word (oldest row at 0, new pixel at 4).
  always_comb begin
    logic signed [18:0] r_s, rv_s, hh_s, top_s, q_s, j_s, idx_s;
    logic signed [18:0] x_s, c_s, ww_s, l_s, b_s;
    r_s   = $signed({2'b0, in_row_q});
    rv_s  = r_s - 19'sd2;
    hh_s  = $signed({3'b0, h_eff});
    top_s = act_push ? r_s : hh_s - 19'sd1;
    q_s   = act_push ? 19'sd4 : 19'sd3;
    x_s   = $signed({{(19-CW){1'b0}}, in_col_q});
    c_s   = $signed({{(19-CW){1'b0}}, out_col_q});
    ww_s  = $signed({{(18-CW){1'b0}}, w_eff});
    // Right-edge outputs come out while the next row's first columns arrive.
    if (in_col_q == CW'(0))      b_s = 19'sd1;
    else if (in_col_q == CW'(1)) b_s = 19'sd2;
    else                         b_s = 19'sd0;
    l_s = (b_s == 19'sd0) ? x_s : ww_s - 19'sd1;
    for (int t = 0; t < 5; t++) begin
      j_s   = mirror(rv_s + 19'(t) - 19'sd2, hh_s);
      idx_s = q_s - (top_s - j_s);
      vsel[t] = (idx_s >= 0 && idx_s <= 19'sd4) ? idx_s[2:0] : 3'd0;
      j_s   = mirror(c_s + 19'(t) - 19'sd2, ww_s);
      idx_s = b_s + l_s - j_s;
      hsel[t] = (idx_s >= 0 && idx_s <= 19'sd5) ? idx_s[2:0] : 3'd0;
    end
  end

  always_comb begin
    fwidth_d  = fwidth_q;
    fheight_d = fheight_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    item_d    = item_q;
    col_d     = col_q;
    if (adv_i) begin
      item_d.valid = accept_i && act;
      item_d.push  = act_push;
      item_d.emit  = emit;
      item_d.last  = last;
      item_d.pixel = in_beat_i.pixel;
      item_d.vsel  = vsel;
      item_d.hsel  = hsel;
      col_d        = in_col_q;
    end
    if (accept_i && act) begin
      if ({1'b0, in_col_q} == w_eff - (CW+1)'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_q + 17'd1;
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if ({1'b0, out_col_q} == w_eff - (CW+1)'(1)) begin
          out_col_d = '0;
          out_row_d = out_row_q + 16'd1;
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  fwidth_d  = cfg_data_i[11:0];
        CFG_FRAME_HEIGHT: fheight_d = cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= 12'd640;
      fheight_q <= 16'd480;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      item_q    <= '0;
      col_q     <= '0;
    end else begin
      fwidth_q  <= fwidth_d;
      fheight_q <= fheight_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      item_q    <= item_d;
      col_q     <= col_d;
    end
  end

  assign rd_col_o = in_col_q;
  assign item_o   = item_q;
  assign col_o    = col_q;

endmodule

// ===== hdl/gbq_colmem.sv =====
// Column store (four rows per column word) with read-modify-write and vertical filter.
// Depends on gbq_pkg.
module gbq_colmem import gbq_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          rd_en_i,
  input  logic [CW-1:0] rd_col_i,
  input  gbq_item_t     item_i,
  input  logic [CW-1:0] col_i,
  output gbq_item_t     item_o,
  output logic [11:0]   vsum_o
);

  logic [31:0] mem [MAX_WIDTH];
  logic [31:0] rdata_q;
  logic [7:0]  vtap [5];
  logic [7:0]  vpick [5];
  logic        wr_en;
  gbq_item_t   item_q;
  logic [11:0] vsum_q, vsum_d;
  logic [15:0] vsum_full;

  // Byte 0 holds the oldest row.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) rdata_q <= mem[rd_col_i];
    if (wr_en)   mem[col_i] <= {item_i.pixel, rdata_q[31:8]};
  end

  assign wr_en = adv_i && item_i.valid && item_i.push;

  always_comb begin
    vtap[0] = rdata_q[7:0];
    vtap[1] = rdata_q[15:8];
    vtap[2] = rdata_q[23:16];
    vtap[3] = rdata_q[31:24];
    vtap[4] = item_i.pixel;
    for (int t = 0; t < 5; t++) begin
      case (item_i.vsel[t])
        3'd0:    vpick[t] = vtap[0];
        3'd1:    vpick[t] = vtap[1];
        3'd2:    vpick[t] = vtap[2];
        3'd3:    vpick[t] = vtap[3];
        3'd4:    vpick[t] = vtap[4];
        default: vpick[t] = vtap[0];
      endcase
    end
    // At most 16 * 255, fits in 12 bits.
    vsum_full = binom5({4'b0, vpick[0]}, {4'b0, vpick[1]}, {4'b0, vpick[2]},
                       {4'b0, vpick[3]}, {4'b0, vpick[4]});
    vsum_d = vsum_full[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      vsum_q <= '0;
    end else if (adv_i) begin
      item_q <= item_i;
      vsum_q <= vsum_d;
    end
  end

  assign item_o = item_q;
  assign vsum_o = vsum_q;

endmodule

// ===== hdl/gbq_hfilt.sv =====
// Horizontal 5-tap filter over column sums, quantizer and output register.
// Depends on gbq_pkg.
module gbq_hfilt import gbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  gbq_item_t   item_i,
  input  logic [11:0] vsum_i,
  output logic        out_valid_o,
  output gbq_out_t    out_beat_o
);

  logic [11:0] hist_q [5];
  logic [11:0] win [6];
  logic [11:0] hpick [5];
  logic [15:0] hsum;
  logic        out_valid_q;
  gbq_out_t    out_q;

  always_comb begin
    win[0] = vsum_i;
    for (int k = 0; k < 5; k++) win[k+1] = hist_q[k];
    for (int t = 0; t < 5; t++) begin
      case (item_i.hsel[t])
        3'd0:    hpick[t] = win[0];
        3'd1:    hpick[t] = win[1];
        3'd2:    hpick[t] = win[2];
        3'd3:    hpick[t] = win[3];
        3'd4:    hpick[t] = win[4];
        3'd5:    hpick[t] = win[5];
        default: hpick[t] = win[0];
      endcase
    end
    hsum = binom5(hpick[0], hpick[1], hpick[2], hpick[3], hpick[4]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && item_i.valid) begin
      hist_q[0] <= vsum_i;
      for (int k = 1; k < 5; k++) hist_q[k] <= hist_q[k-1];
    end
    if (adv_i) begin
      out_q.blurred_level <= {hsum[15:13], 5'b11111};
      out_q.last_in_frame <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= item_i.valid && item_i.emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== hdl/gaussian_blur_quantize_unit.sv =====
// 5x5 binomial blur with 8-level quantization over a raster gray stream.
// Depends on gbq_pkg, gbq_ctrl, gbq_colmem, gbq_hfilt.

// One beat is taken every clock while the output is not stalled, and a
// result is registered in the control, column-store and output stages in
// turn. The rate is set by the single column store: one read and one
// write-back per beat, one word per frame column holding the four previous
// rows. The output for raster position p comes with the push of position
// p+2W+2; the last 2W+2 outputs of a frame need drain beats (operation=1)
// after the frame's final pixel. Drains before that and pushes after it are
// swallowed. A width/height config write restarts the frame. The column
// store has no reset or clearing pass; only pixels of the current frame
// are ever read. Width is clamped to 3..MAX_WIDTH and height to at least 3.
module gaussian_blur_quantize_unit import gbq_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gbq_in_t               in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gbq_out_t              out_beat_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          adv, accept;
  logic [CW-1:0] rd_col, s1_col;
  gbq_item_t     s1_item, s2_item;
  logic [11:0]   s2_vsum;

  // Whole pipe moves unless a finished beat is held at the output.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  gbq_ctrl #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .adv_i       (adv),
    .in_beat_i   (in_beat_i),
    .rd_col_o    (rd_col),
    .item_o      (s1_item),
    .col_o       (s1_col)
  );

  gbq_colmem #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_colmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .rd_en_i  (accept),
    .rd_col_i (rd_col),
    .item_i   (s1_item),
    .col_i    (s1_col),
    .item_o   (s2_item),
    .vsum_o   (s2_vsum)
  );

  gbq_hfilt u_hfilt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (s2_item),
    .vsum_i      (s2_vsum),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule
